[src/lc4b6b_pkg.sv]
package lc4b6b_pkg;

    typedef logic [3:0] nibble_t;
    typedef logic [5:0] symbol_t;
    typedef logic [7:0] byte_t;

    function automatic symbol_t sym_code(input nibble_t nib);
        symbol_t code;
        unique case (nib)
            4'h0:    code = 6'h15;
            4'h1:    code = 6'h31;
            4'h2:    code = 6'h32;
            4'h3:    code = 6'h23;
            4'h4:    code = 6'h34;
            4'h5:    code = 6'h25;
            4'h6:    code = 6'h26;
            4'h7:    code = 6'h16;
            4'h8:    code = 6'h1A;
            4'h9:    code = 6'h19;
            4'hA:    code = 6'h2A;
            4'hB:    code = 6'h0B;
            4'hC:    code = 6'h2C;
            4'hD:    code = 6'h0D;
            4'hE:    code = 6'h0E;
            default: code = 6'h1C;
        endcase
        return code;
    endfunction

endpackage

[src/line_code_4b6b_encoder.sv]
// The first output beat is registered: it is valid in the cycle after the input beat is
// taken; a second beat (if any) waits in the pending-beat slot until the first is taken.
// Throughput: one input beat per cycle when it yields one output beat and the output is
// not stalled; no input is taken while a second beat waits in the pending-beat slot.
// Reset (rst_n low, asynchronous) clears the output valids and the leftover code bits.
module line_code_4b6b_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] code_byte,
    output logic       end_of_message
);

    logic                  out_valid_reg,  out_valid_next;
    lc4b6b_pkg::byte_t     code_byte_reg,  code_byte_next;
    logic                  eom_reg,        eom_next;
    logic                  pend_valid_reg, pend_valid_next;
    lc4b6b_pkg::byte_t     pend_byte_reg,  pend_byte_next;
    logic                  pend_eom_reg,   pend_eom_next;
    lc4b6b_pkg::nibble_t   left_bits_reg,  left_bits_next;
    logic                  left_valid_reg, left_valid_next;

    logic                  in_fire;
    logic                  out_fire;
    logic [11:0]           bits12;
    lc4b6b_pkg::byte_t     first_byte;
    lc4b6b_pkg::byte_t     second_byte;
    logic                  two_beats;

    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = pend_valid_reg || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;

    assign bits12 = {lc4b6b_pkg::sym_code(data_byte[7:4]),
                     lc4b6b_pkg::sym_code(data_byte[3:0])};

    always_comb
    begin
        if (left_valid_reg)
        begin
            first_byte  = {left_bits_reg, bits12[11:8]};
            second_byte = bits12[7:0];
        end
        else
        begin
            first_byte  = bits12[11:4];
            second_byte = {bits12[3:0], 4'b0000};
        end
        two_beats = left_valid_reg || is_last;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        code_byte_next  = code_byte_reg;
        eom_next        = eom_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_eom_next   = pend_eom_reg;
        left_bits_next  = left_bits_reg;
        left_valid_next = left_valid_reg;

        if (in_fire)
        begin
            out_valid_next  = 1'b1;
            code_byte_next  = first_byte;
            eom_next        = 1'b0;
            pend_valid_next = two_beats;
            pend_byte_next  = second_byte;
            pend_eom_next   = is_last;
            left_bits_next  = bits12[3:0];
            left_valid_next = !left_valid_reg && !is_last;
        end
        else if (out_fire)
        begin
            if (pend_valid_reg)
            begin
                code_byte_next  = pend_byte_reg;
                eom_next        = pend_eom_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            eom_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_eom_reg   <= 1'b0;
            left_bits_reg  <= '0;
            left_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            eom_reg        <= eom_next;
            pend_valid_reg <= pend_valid_next;
            pend_eom_reg   <= pend_eom_next;
            left_bits_reg  <= left_bits_next;
            left_valid_reg <= left_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_byte_reg <= code_byte_next;
        pend_byte_reg <= pend_byte_next;
    end

    assign out_valid      = out_valid_reg;
    assign code_byte      = code_byte_reg;
    assign end_of_message = eom_reg;

    // pending beat always sits behind a valid output beat
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending beat without output beat");

    // a two-beat item always drains the leftover nibble
    a_pend_no_left: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !left_valid_reg)
        else $error("leftover bits held with a pending beat");

    // the final beat of a message leaves nothing pending
    a_eom_no_left: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eom_reg) |-> !left_valid_reg)
        else $error("leftover bits after end of message");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_last) |=> (!left_valid_reg && pend_valid_reg && pend_eom_reg))
        else $error("last beat did not flush");

endmodule

[tb/sv/lc4b6b_checker.sv]
module lc4b6b_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] code_byte,
    input  logic       end_of_message,
    output int         mismatches,
    output int         pending
);

    typedef struct packed {
        lc4b6b_pkg::byte_t code;
        logic              eom;
    } code_beat_t;

    // 4b6b symbols, entry n at bits [6n +: 6]
    localparam logic [95:0] SYMBOLS = {
        6'h1C, 6'h0E, 6'h0D, 6'h2C, 6'h0B, 6'h2A, 6'h19, 6'h1A,
        6'h16, 6'h26, 6'h25, 6'h34, 6'h23, 6'h32, 6'h31, 6'h15
    };

    code_beat_t          expected_code [$];
    lc4b6b_pkg::nibble_t carry_bits;
    logic                carry_valid;
    int                  out_beats;

    initial
    begin
        mismatches  = 0;
        pending     = 0;
        carry_bits  = '0;
        carry_valid = 1'b0;
        out_beats   = 0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at output beat %0d: %s", out_beats, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        logic [11:0] bits12;
        logic [15:0] bits16;
        code_beat_t  want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                bits12 = {SYMBOLS[data_byte[7:4]*6 +: 6], SYMBOLS[data_byte[3:0]*6 +: 6]};
                if (!carry_valid)
                begin
                    expected_code.push_back('{bits12[11:4], 1'b0});
                    if (is_last)
                    begin
                        expected_code.push_back('{{bits12[3:0], 4'h0}, 1'b1});
                    end
                    else
                    begin
                        carry_bits  = bits12[3:0];
                        carry_valid = 1'b1;
                    end
                end
                else
                begin
                    bits16 = {carry_bits, bits12};
                    expected_code.push_back('{bits16[15:8], 1'b0});
                    expected_code.push_back('{bits16[7:0], is_last});
                    carry_bits  = '0;
                    carry_valid = 1'b0;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_code.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat code_byte=%02h eom=%0b",
                                              code_byte, end_of_message));
                end
                else
                begin
                    want = expected_code.pop_front();
                    if (code_byte !== want.code)
                    begin
                        report_mismatch($sformatf("code_byte %02h, expected %02h",
                                                  code_byte, want.code));
                    end
                    if (end_of_message !== want.eom)
                    begin
                        report_mismatch($sformatf("end_of_message %0b, expected %0b",
                                                  end_of_message, want.eom));
                    end
                end
                out_beats++;
            end
            pending = expected_code.size();
        end
    end

endmodule

[tb/sv/tb.sv]
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BYTES_PER_PHASE = 180;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    lc4b6b_pkg::byte_t data_byte;
    logic              is_last;
    logic              out_valid;
    logic              out_stall;
    lc4b6b_pkg::byte_t code_byte;
    logic              end_of_message;

    int mismatches;
    int pending;
    int idle_pct;
    int stall_pct;
    int cycle_count;

    always #5 clk = ~clk;

    line_code_4b6b_encoder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .is_last        (is_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_byte      (code_byte),
        .end_of_message (end_of_message)
    );

    lc4b6b_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .is_last        (is_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_byte      (code_byte),
        .end_of_message (end_of_message),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_beat(input lc4b6b_pkg::byte_t b, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        is_last   <= last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++)
        begin
            send_beat(lc4b6b_pkg::byte_t'($urandom_range(255)), k == len - 1);
        end
    endtask

    initial
    begin
        int sent;
        int len;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = '0;
        is_last     = 1'b0;
        out_stall   = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        cycle_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // one-byte messages: flush from an empty carry
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        // two bytes: last arrives with four bits carried
        send_beat(8'h0F, 1'b0);
        send_beat(8'hF0, 1'b1);
        // three bytes: last arrives with nothing carried
        send_beat(8'h01, 1'b0);
        send_beat(8'h23, 1'b0);
        send_beat(8'h45, 1'b1);
        send_beat(8'h67, 1'b0);
        send_beat(8'h89, 1'b0);
        send_beat(8'hAB, 1'b0);
        send_beat(8'hCD, 1'b1);
        send_beat(8'hEF, 1'b0);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b1);
        send_beat(8'h80, 1'b0);
        send_beat(8'h7F, 1'b1);
        send_beat(8'hFE, 1'b0);
        send_beat(8'hDC, 1'b0);
        send_beat(8'hBA, 1'b0);
        send_beat(8'h98, 1'b0);
        send_beat(8'h76, 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 59; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(12, 24);
                else
                    len = $urandom_range(1, 6);
                send_message(len);
                sent += len;
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/lc4b6b_pkg.sv
src/line_code_4b6b_encoder.sv
tb/sv/lc4b6b_checker.sv
tb/sv/tb.sv
